// ----- rtl/core/gated_path_length_odometer_top_assert.svh -----
// assertion macros for the odometer top level
`ifndef GATED_PATH_LENGTH_ODOMETER_TOP_ASSERT_SVH
`define GATED_PATH_LENGTH_ODOMETER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GPLO_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("gplo implication check failed");

// next-cycle implication
`define GPLO_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gplo next-cycle check failed");

`else

`define GPLO_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define GPLO_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/gplo_pkg.sv -----
package gplo_pkg;

	// default parameter values
	localparam int COORD_WIDTH_DEF   = 32;
	localparam int MILEAGE_WIDTH_DEF = 48;

	// fixed field widths
	localparam int TMO_W      = 8;
	localparam int LIM_W      = 16;
	localparam int SQ_W       = 2 * LIM_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int ROOT_W     = LIM_W;
	localparam int REM_W      = ROOT_W + 2;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
	localparam int AXES       = 3;
	localparam int AXIS_W     = 2;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP    = 1'b1;

	// register reset values
	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 8'd10;
	localparam logic [LIM_W-1:0] JUMP_RESET    = 16'd10000;
	localparam logic [TMO_W-1:0] AGE_MAX       = 8'hff;

	// request opcodes
	localparam logic [1:0] OP_CLUTCH_A = 2'd0;
	localparam logic [1:0] OP_CLUTCH_B = 2'd1;
	localparam logic [1:0] OP_POSITION = 2'd2;
	localparam logic [1:0] OP_TICK     = 2'd3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQUARE,
		ST_ACCUM,
		ST_LIMSQ,
		ST_CHECK,
		ST_SQRT,
		ST_ADD_FIN
	} state_t;

endpackage

// ----- rtl/core/gated_path_length_odometer_top.sv -----
// Gated path-length odometer.
// Input stream s_*: tuser carries the opcode (clutch report a, clutch report b,
// position update, tick); tdata carries the clutch flag and the x, y, z
// coordinates. One request is taken at a time: s_tready is high only while the
// sequencer is idle.
// Output stream m_*: one result per request; tuser is the recording flag, tlast
// marks the tick that ended a recording, tdata is the mileage in millimetres.
// Config port cfg_*: index 0 timeout in ticks, index 1 jump limit in mm; always
// ready; it must be written only while no request is in flight, which the block
// does not enforce. A clutch report, a position update or a tick that does not
// record goes straight to the result load, after which the sequencer is idle
// again. A recording tick runs three axis passes of difference, square and
// accumulate, the limit check, the bit-serial square root, one root bit per
// cycle, then the add and the result load. A step beyond the jump limit skips
// the square root and the add.
// A finished result sits in an output register, so the next request is accepted
// while the receiver stalls; only a second result waits for m_tready.
// Reset clears clutches, positions, mileage and recording, saturates both
// channel ages, and loads the register defaults.
`include "gated_path_length_odometer_top_assert.svh"

module gated_path_length_odometer_top
	import gplo_pkg::*;
#(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int MILEAGE_WIDTH = MILEAGE_WIDTH_DEF,
	localparam int IN_DATA_W    = ((1 + 3 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_DATA_W   = ((MILEAGE_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata: clutch, pos_x, pos_y, pos_z, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: opcode
	input  logic [1:0]            s_tuser,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata: mileage_mm, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// m_tuser: recording
	output logic [0:0]            m_tuser,
	output logic                  m_tlast,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DW = COORD_WIDTH + 1;

	state_t state_q, state_d;

	// configuration registers
	logic [TMO_W-1:0] timeout_q;
	logic [LIM_W-1:0] jump_q;

	// odometer state
	logic clutch_a_q, clutch_b_q;
	logic [TMO_W-1:0] age_a_q, age_b_q;
	logic rec_q, ended_q;
	logic [1:0] op_q;
	logic [MILEAGE_WIDTH-1:0] mileage_q;
	logic signed [COORD_WIDTH-1:0] cur_pos_q [AXES];
	logic signed [COORD_WIDTH-1:0] prev_pos_q [AXES];

	// step arithmetic
	logic [AXIS_W-1:0] axis_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic reject_q;
	logic [LIM_W-1:0] ad_q;
	logic [SQ_W-1:0] sq_q;
	logic [SQ_W-1:0] limsq_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;

	// output register
	logic out_valid_q;
	logic out_rec_q, out_end_q;
	logic [MILEAGE_WIDTH-1:0] out_mile_q;

	// control
	logic accept, load_out, do_add;

	// tick evaluation of ages and clutches
	logic [TMO_W-1:0] age_a_inc, age_b_inc;
	logic ca_tick, cb_tick, rec_tick;

	assign age_a_inc = (age_a_q == AGE_MAX) ? age_a_q : age_a_q + TMO_W'(1);
	assign age_b_inc = (age_b_q == AGE_MAX) ? age_b_q : age_b_q + TMO_W'(1);
	assign ca_tick   = clutch_a_q && !(age_a_inc > timeout_q);
	assign cb_tick   = clutch_b_q && !(age_b_inc > timeout_q);
	assign rec_tick  = ca_tick || cb_tick;

	// absolute axis difference, previous minus current
	logic [DW-1:0] diff, abs_diff;
	logic over_lim;

	assign diff     = {prev_pos_q[0][COORD_WIDTH-1], prev_pos_q[0]}
		- {cur_pos_q[0][COORD_WIDTH-1], cur_pos_q[0]};
	assign abs_diff = diff[DW-1] ? (~diff + DW'(1)) : diff;
	assign over_lim = abs_diff > DW'(jump_q);

	// one square-root step
	logic [REM_W-1:0] rem_sh, trial;
	logic root_bit;

	assign rem_sh   = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign root_bit = rem_sh >= trial;

	// saturating mileage add
	logic [MILEAGE_WIDTH:0] mile_sum;
	logic [MILEAGE_WIDTH-1:0] mile_sat;

	assign mile_sum = {1'b0, mileage_q} + (MILEAGE_WIDTH + 1)'(root_q);
	assign mile_sat = mile_sum[MILEAGE_WIDTH] ? {MILEAGE_WIDTH{1'b1}}
		: mile_sum[MILEAGE_WIDTH-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == OP_TICK && rec_tick) ? ST_DIFF : ST_ADD_FIN;
				end
			end
			ST_DIFF:   state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_ACCUM;
			ST_ACCUM:  state_d = (axis_q == AXIS_W'(AXES - 1)) ? ST_LIMSQ : ST_DIFF;
			ST_LIMSQ:  state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = (reject_q || sum_q > SUM_W'(limsq_q)) ? ST_ADD_FIN : ST_SQRT;
			end
			ST_SQRT: begin
				if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
					state_d = ST_ADD_FIN;
				end
			end
			ST_ADD_FIN: begin
				if (!do_add && load_out) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// handshake and control outputs
	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE:    s_tready = 1'b1;
			ST_ADD_FIN: load_out = !do_add && (!out_valid_q || m_tready);
			default: begin
				s_tready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			timeout_q   <= TIMEOUT_RESET;
			jump_q      <= JUMP_RESET;
			clutch_a_q  <= 1'b0;
			clutch_b_q  <= 1'b0;
			age_a_q     <= AGE_MAX;
			age_b_q     <= AGE_MAX;
			rec_q       <= 1'b0;
			ended_q     <= 1'b0;
			op_q        <= OP_CLUTCH_A;
			mileage_q   <= '0;
			axis_q      <= '0;
			cnt_q       <= '0;
			reject_q    <= 1'b0;
			do_add      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				cur_pos_q[i]  <= '0;
				prev_pos_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			// register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
					CFG_JUMP:    jump_q    <= cfg_data[LIM_W-1:0];
				endcase
			end

			// request acceptance
			if (accept) begin
				op_q     <= s_tuser;
				ended_q  <= (s_tuser == OP_TICK) && rec_q && !rec_tick;
				axis_q   <= '0;
				reject_q <= 1'b0;
				do_add   <= 1'b0;
				unique case (s_tuser)
					OP_CLUTCH_A: begin
						clutch_a_q <= s_tdata[0];
						age_a_q    <= '0;
					end
					OP_CLUTCH_B: begin
						clutch_b_q <= s_tdata[0];
						age_b_q    <= '0;
					end
					OP_POSITION: begin
						cur_pos_q[0] <= s_tdata[COORD_WIDTH:1];
						cur_pos_q[1] <= s_tdata[2*COORD_WIDTH:COORD_WIDTH+1];
						cur_pos_q[2] <= s_tdata[3*COORD_WIDTH:2*COORD_WIDTH+1];
					end
					OP_TICK: begin
						age_a_q    <= age_a_inc;
						age_b_q    <= age_b_inc;
						clutch_a_q <= ca_tick;
						clutch_b_q <= cb_tick;
						rec_q      <= rec_tick;
					end
				endcase
			end

			// axis pass: rotate both position lines so axis zero is always read
			if (state_q == ST_DIFF) begin
				if (over_lim) begin
					reject_q <= 1'b1;
				end
				for (int i = 0; i < AXES; i++) begin
					cur_pos_q[i]  <= cur_pos_q[(i + 1) % AXES];
					prev_pos_q[i] <= prev_pos_q[(i + 1) % AXES];
				end
			end
			if (state_q == ST_ACCUM) begin
				axis_q <= axis_q + AXIS_W'(1);
			end

			// square-root step count
			if (state_q == ST_CHECK) begin
				cnt_q <= '0;
			end else if (state_q == ST_SQRT) begin
				cnt_q <= cnt_q + SQRT_CNT_W'(1);
				if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
					do_add <= 1'b1;
				end
			end

			// saturating add of the accepted step
			if (state_q == ST_ADD_FIN && do_add) begin
				mileage_q <= mile_sat;
				do_add    <= 1'b0;
			end

			// result hand-off, mileage clear and position history
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (op_q == OP_TICK) begin
					for (int i = 0; i < AXES; i++) begin
						prev_pos_q[i] <= cur_pos_q[i];
					end
					if (!rec_q) begin
						mileage_q <= '0;
					end
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// step datapath and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= '0;
		end
		if (state_q == ST_DIFF) begin
			ad_q <= abs_diff[LIM_W-1:0];
		end
		if (state_q == ST_SQUARE) begin
			sq_q <= ad_q * ad_q;
		end
		if (state_q == ST_ACCUM) begin
			sum_q <= sum_q + SUM_W'(sq_q);
		end
		if (state_q == ST_LIMSQ) begin
			limsq_q <= jump_q * jump_q;
		end
		if (state_q == ST_CHECK) begin
			rad_q  <= sum_q[SQ_W-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end
		if (state_q == ST_SQRT) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= root_bit ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], root_bit};
		end
		if (load_out) begin
			out_rec_q  <= rec_q;
			out_end_q  <= ended_q;
			out_mile_q <= mileage_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = OUT_DATA_W'(out_mile_q);
	assign m_tuser[0] = out_rec_q;
	assign m_tlast    = out_end_q;

	// one request in flight at a time
	`GPLO_ASSERT_NXT(a_single_request, clk, arst_n, accept, !s_tready)
	// an accepted step never exceeds the jump limit
	`GPLO_ASSERT_IMP(a_step_in_limit, clk, arst_n, state_q == ST_ADD_FIN && do_add,
		root_q <= jump_q)
	// the total is cleared once a recording ends
	`GPLO_ASSERT_NXT(a_clear_on_end, clk, arst_n, load_out && ended_q, mileage_q == '0)

endmodule

// ----- test/gplo_checker.sv -----
module gplo_checker
	import gplo_pkg::*;
#(
	parameter int IN_W  = 104,
	parameter int OUT_W = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// s_tdata: clutch, pos_x, pos_y, pos_z, zero pad
	input  logic [IN_W-1:0]       s_tdata,
	// s_tuser: opcode
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata: mileage_mm, zero pad
	input  logic [OUT_W-1:0]      m_tdata,
	// m_tuser: recording
	input  logic [0:0]            m_tuser,
	input  logic                  m_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    failures,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int MW = MILEAGE_WIDTH_DEF;
	localparam logic [MW-1:0] MILEAGE_FULL = '1;

	// one reading of the odometer as the block should report it
	typedef struct packed {
		logic          recording;
		logic          ended;
		logic [MW-1:0] mileage;
	} odo_reading_t;

	odo_reading_t readings_due[$];

	// own copy of the block state and registers
	logic                 clutch_a;
	logic                 clutch_b;
	logic [TMO_W-1:0]     age_a;
	logic [TMO_W-1:0]     age_b;
	logic                 recording;
	logic [MW-1:0]        total_mm;
	logic signed [CW-1:0] cur_pos [AXES];
	logic signed [CW-1:0] prev_pos [AXES];
	logic [TMO_W-1:0]     timeout_now;
	logic [LIM_W-1:0]     jump_now;

	initial begin
		failures = 0;
		pending  = 0;
	end

	// integer floor of the square root, one bit at a time from the top
	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	// length of the step from the previous to the current position
	function automatic logic [63:0] step_mm(output logic accepted);
		logic signed [63:0] d;
		logic [63:0]        ad;
		logic [63:0]        sum;
		logic [63:0]        lim;
		lim      = 64'(jump_now);
		sum      = '0;
		accepted = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			d  = prev_pos[i] - cur_pos[i];
			ad = d[63] ? -d : d;
			if (ad > lim)
				accepted = 1'b0;
			sum = sum + ad * ad;
		end
		if (sum > lim * lim)
			accepted = 1'b0;
		return floor_root(sum);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		odo_reading_t due;
		logic         ended;
		logic         accepted;
		logic [63:0]  step;
		if (!arst_n) begin
			clutch_a    = 1'b0;
			clutch_b    = 1'b0;
			age_a       = AGE_MAX;
			age_b       = AGE_MAX;
			recording   = 1'b0;
			total_mm    = '0;
			timeout_now = TIMEOUT_RESET;
			jump_now    = JUMP_RESET;
			for (int i = 0; i < AXES; i++) begin
				cur_pos[i]  = '0;
				prev_pos[i] = '0;
			end
			readings_due.delete();
			failures = 0;
			pending  = 0;
		end else begin
			// compare a result taken by the receiver
			if (m_tvalid && m_tready) begin
				if (readings_due.size() == 0) begin
					$error("result with nothing due: mileage_mm %0d", m_tdata[MW-1:0]);
					failures++;
				end else begin
					due = readings_due.pop_front();
					if (m_tuser[0] !== due.recording) begin
						$error("recording: expected %0d, got %0d", due.recording, m_tuser[0]);
						failures++;
					end
					if (m_tlast !== due.ended) begin
						$error("record_ended: expected %0d, got %0d", due.ended, m_tlast);
						failures++;
					end
					if (m_tdata !== OUT_W'(due.mileage)) begin
						$error("mileage_mm: expected %0d, got %0d", due.mileage, m_tdata);
						failures++;
					end
				end
			end

			// predict the reading for a request taken by the block
			if (s_tvalid && s_tready) begin
				ended = 1'b0;
				case (s_tuser)
					OP_CLUTCH_A: begin
						clutch_a = s_tdata[0];
						age_a    = '0;
					end
					OP_CLUTCH_B: begin
						clutch_b = s_tdata[0];
						age_b    = '0;
					end
					OP_POSITION: begin
						cur_pos[0] = s_tdata[CW:1];
						cur_pos[1] = s_tdata[2*CW:CW+1];
						cur_pos[2] = s_tdata[3*CW:2*CW+1];
					end
					default: begin
						// tick: age both channels, drop silent ones, add the step
						if (age_a != AGE_MAX)
							age_a = age_a + 1'b1;
						if (age_b != AGE_MAX)
							age_b = age_b + 1'b1;
						if (age_a > timeout_now)
							clutch_a = 1'b0;
						if (age_b > timeout_now)
							clutch_b = 1'b0;
						if (clutch_a || clutch_b) begin
							recording = 1'b1;
						end else begin
							ended     = recording;
							recording = 1'b0;
						end
						if (recording) begin
							step = step_mm(accepted);
							if (accepted) begin
								if (step > 64'(MILEAGE_FULL - total_mm))
									total_mm = MILEAGE_FULL;
								else
									total_mm = total_mm + MW'(step);
							end
						end
						for (int i = 0; i < AXES; i++)
							prev_pos[i] = cur_pos[i];
					end
				endcase
				due.recording = recording;
				due.ended     = ended;
				due.mileage   = total_mm;
				if (s_tuser == OP_TICK && !recording)
					total_mm = '0;
				readings_due.push_back(due);
			end

			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TIMEOUT)
					timeout_now = cfg_data[TMO_W-1:0];
				else if (cfg_index == CFG_JUMP)
					jump_now = cfg_data[LIM_W-1:0];
			end

			pending = readings_due.size();
		end
	end

endmodule

// ----- test/tb_gated_path_length_odometer_top.sv -----
module tb_gated_path_length_odometer_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gplo_pkg::*;

	localparam int IN_W           = ((1 + 3 * COORD_WIDTH_DEF + 7) / 8) * 8;
	localparam int OUT_W          = ((MILEAGE_WIDTH_DEF + 7) / 8) * 8;
	localparam int STALL_LIMIT    = 4000;
	localparam int PHASE_REQUESTS = 195;
	localparam int PHASES         = 6;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic [0:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int          check_failures;
	int          readings_pending;
	int          requests_sent;
	int          quiet_cycles;
	bit          calm;
	logic [31:0] walk [AXES];
	logic [7:0]  timeout_now;
	logic [15:0] jump_now;

	gated_path_length_odometer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gplo_checker #(
		.IN_W  (IN_W),
		.OUT_W (OUT_W)
	) odo_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (check_failures),
		.pending   (readings_pending)
	);

	always #5 clk = ~clk;

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 23);
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// one request, with random gaps before it unless calm
	task automatic send_request(input logic [1:0] op, input logic cl,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		while (!calm && $urandom_range(0, 99) < 23) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_W'({z, y, x, cl});
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic report(input logic [1:0] op, input logic cl);
		send_request(op, cl, $urandom(), $urandom(), $urandom());
	endtask

	task automatic move_to(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		send_request(OP_POSITION, 1'($urandom_range(0, 1)), x, y, z);
	endtask

	task automatic clock_tick();
		send_request(OP_TICK, 1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
	endtask

	// hold the sender until every reading has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (readings_pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain();
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input logic [7:0] tmo, input logic [15:0] lim);
		timeout_now = tmo;
		jump_now    = lim;
		write_reg(CFG_TIMEOUT, {8'($urandom()), tmo});
		write_reg(CFG_JUMP, lim);
	endtask

	// random walk step of up to span mm per axis, now and then a wild jump
	task automatic wander(input int span);
		int d;
		for (int i = 0; i < AXES; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				walk[i] = $urandom();
			end else begin
				d       = int'($urandom_range(0, 2 * span)) - span;
				walk[i] = walk[i] + d;
			end
		end
		move_to(walk[0], walk[1], walk[2]);
	endtask

	initial begin : stimulus
		int         phase_end;
		int         steps;
		int         span;
		int         chan;
		logic [1:0] keep_op;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = OP_CLUTCH_A;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_TIMEOUT;
		cfg_data     = '0;
		calm         = 1'b0;
		quiet_cycles = 0;
		requests_sent = 0;
		timeout_now  = TIMEOUT_RESET;
		jump_now     = JUMP_RESET;
		for (int i = 0; i < AXES; i++)
			walk[i] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle tick, clean step, rejected steps, coordinate extremes
		clock_tick();
		report(OP_CLUTCH_A, 1'b1);
		clock_tick();
		move_to(32'd3000, 32'd4000, 32'd0);
		clock_tick();
		move_to(32'd3000, 32'd4000, 32'd12000);
		clock_tick();
		move_to(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		clock_tick();
		move_to(32'h7fff_fff0, 32'h8000_0005, 32'hffff_ffff);
		clock_tick();
		// hand over to channel b, then release both
		report(OP_CLUTCH_B, 1'b1);
		report(OP_CLUTCH_A, 1'b0);
		clock_tick();
		report(OP_CLUTCH_B, 1'b0);
		clock_tick();

		// timeout of 1, zero jump limit: only a standstill counts
		set_limits(8'd1, 16'd0);
		report(OP_CLUTCH_A, 1'b1);
		clock_tick();
		move_to(32'h7fff_fff1, 32'h8000_0005, 32'hffff_ffff);
		clock_tick();
		clock_tick();

		// longest timeout, widest limit: step exactly at and just past the limit
		set_limits(8'd255, 16'hffff);
		report(OP_CLUTCH_A, 1'b1);
		move_to(32'd0, 32'd0, 32'd0);
		clock_tick();
		move_to(32'd65535, 32'd0, 32'd0);
		clock_tick();
		move_to(32'd131070, 32'd1, 32'd0);
		clock_tick();
		report(OP_CLUTCH_A, 1'b0);
		clock_tick();

		// random sessions over several register settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_limits(8'd10, 16'd10000);
				1: set_limits(8'd1, 16'hffff);
				2: set_limits(8'd255, 16'd0);
				3: set_limits(8'd3, 16'd200);
				4: set_limits(8'd255, 16'd1);
				default: set_limits(8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)));
			endcase
			calm      = (p == 3);
			phase_end = requests_sent + PHASE_REQUESTS;
			while (requests_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: any opcode, any content
					send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						$urandom(), $urandom(), $urandom());
				end else begin
					// a session: engage, travel, then release or fall silent
					chan = $urandom_range(0, 2);
					if (chan != 1)
						report(OP_CLUTCH_A, 1'b1);
					if (chan != 0)
						report(OP_CLUTCH_B, 1'b1);
					steps = $urandom_range(1, 12);
					for (int s = 0; s < steps; s++) begin
						if ($urandom_range(0, 3) == 0) begin
							if (chan == 2)
								keep_op = $urandom_range(0, 1) ? OP_CLUTCH_B : OP_CLUTCH_A;
							else
								keep_op = (chan == 0) ? OP_CLUTCH_A : OP_CLUTCH_B;
							report(keep_op, 1'b1);
						end
						if ($urandom_range(0, 9) == 0)
							span = int'(jump_now) + 2;
						else
							span = int'(jump_now) / 2 + 1;
						if ($urandom_range(0, 4) != 0)
							wander(span);
						if ($urandom_range(0, 9) == 0)
							wander(span);
						clock_tick();
					end
					case ($urandom_range(0, 2))
						0: begin
							if (chan != 1)
								report(OP_CLUTCH_A, 1'b0);
							if (chan != 0)
								report(OP_CLUTCH_B, 1'b0);
							clock_tick();
						end
						1: begin
							if (timeout_now <= 8'd12) begin
								repeat (int'(timeout_now) + 1) clock_tick();
							end else begin
								report(OP_CLUTCH_A, 1'b0);
								report(OP_CLUTCH_B, 1'b0);
								clock_tick();
							end
						end
						default: ;
					endcase
					if ($urandom_range(0, 19) == 0)
						drain();
				end
			end
		end
		calm = 1'b0;

		drain();
		repeat (40) @(negedge clk);
		if (check_failures == 0 && readings_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- gated_path_length_odometer_top.f -----
+incdir+rtl/core
rtl/core/gplo_pkg.sv
rtl/core/gated_path_length_odometer_top.sv
test/gplo_checker.sv
test/tb_gated_path_length_odometer_top.sv
